[sv/ofts_pkg.sv]
package ofts_pkg;

	localparam logic [2:0] REQ_ADD    = 3'd0;
	localparam logic [2:0] REQ_REMOVE = 3'd1;
	localparam logic [2:0] REQ_YIELD  = 3'd2;
	localparam logic [2:0] REQ_SELECT = 3'd3;
	localparam logic [2:0] REQ_TICK   = 3'd4;

	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_FULL       = 2'd1;
	localparam logic [1:0] STAT_NONE_READY = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND  = 2'd3;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] task_id;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] grant_id;
		logic [3:0] slot_index;
	} resp_t;

	typedef struct packed {
		logic load;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic resp_busy;
	} dp_stat_t;

endpackage

[sv/oldest_first_task_slot_arbiter.sv]
// Oldest-first task slot arbiter. Each request (add, remove, yield, select,
// tick) is answered by exactly one response. A request is handled by one pass
// over the slot table, one slot per cycle through the task and age memories.
// The response is registered when the request commits after the scan. The
// next request is accepted only once the arbiter is back in idle after that
// commit, so one request is handled at a time. A response still waiting on
// resp_ready holds back the commit of the following request, and with it the
// next acceptance.
// Select grants the ready, non-busy slot with the greatest age, lowest slot
// on a tie; tick ages every slot, saturating at 2**AGE_BITS - 1. For more
// than 16 slots, slot_index carries the low four bits of the slot number.
module oldest_first_task_slot_arbiter import ofts_pkg::*; #(
	parameter int NUM_SLOTS = 16,
	parameter int AGE_BITS  = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	input  req_t  req,
	output logic  resp_valid,
	input  logic  resp_ready,
	output resp_t resp
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	ofts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ofts_datapath #(
		.NUM_SLOTS (NUM_SLOTS),
		.AGE_BITS  (AGE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cmd        (cmd),
		.stat       (stat),
		.resp_valid (resp_valid),
		.resp_ready (resp_ready),
		.resp       (resp)
	);

endmodule

[sv/ofts_ctrl.sv]
module ofts_ctrl import ofts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		req_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_done) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				// hold until the previous response has been taken
				if (!stat.resp_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

[sv/ofts_datapath.sv]
module ofts_datapath import ofts_pkg::*; #(
	parameter int NUM_SLOTS = 16,
	parameter int AGE_BITS  = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  ctl_cmd_t cmd,
	output dp_stat_t stat,
	output logic     resp_valid,
	input  logic     resp_ready,
	output resp_t    resp
);

	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

	logic [7:0]          task_mem [NUM_SLOTS];
	logic [AGE_BITS-1:0] age_mem  [NUM_SLOTS];

	logic [NUM_SLOTS-1:0] valid_q, busy_q, age_ok_q;
	logic [2:0]           req_type_q;
	logic [7:0]           task_id_q;
	logic                 rd_active_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic                 proc_vld_s1;
	logic [IDX_W-1:0]     proc_idx_s1;
	logic [7:0]           task_rd_s1;
	logic [AGE_BITS-1:0]  age_rd_s1;
	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic [AGE_BITS-1:0]  best_age_q;
	logic [7:0]           best_task_q;
	logic                 resp_valid_q;
	resp_t                resp_q;

	logic                 cur_valid, cur_busy, cur_match;
	logic [AGE_BITS-1:0]  cur_age, cur_age_inc;
	logic                 take;
	logic                 age_we;
	logic [IDX_W-1:0]     age_waddr;
	logic [AGE_BITS-1:0]  age_wdata;
	logic                 task_we;
	logic [IDX_W+3:0]     pick_wide;
	resp_t                resp_d;

	assign cur_valid   = valid_q[proc_idx_s1];
	assign cur_busy    = busy_q[proc_idx_s1];
	assign cur_match   = cur_valid && (task_rd_s1 == task_id_q);
	assign cur_age     = age_ok_q[proc_idx_s1] ? age_rd_s1 : '0;
	assign cur_age_inc = (cur_age == '1) ? cur_age : cur_age + 1'b1;
	assign pick_wide   = {4'd0, pick_q};

	// take: the slot now in the scan replaces the current pick
	always_comb begin
		take = 1'b0;
		if (proc_vld_s1) begin
			case (req_type_q)
				REQ_ADD:    take = !cur_valid && !found_q;
				REQ_REMOVE: take = cur_match && !found_q;
				REQ_YIELD:  take = cur_match && !found_q;
				REQ_SELECT: take = cur_valid && !cur_busy && (!found_q || cur_age > best_age_q);
				default:    take = 1'b0;
			endcase
		end
	end

	always_comb begin
		age_we    = 1'b0;
		age_waddr = proc_idx_s1;
		age_wdata = cur_age_inc;
		if (proc_vld_s1 && req_type_q == REQ_TICK) begin
			age_we = 1'b1;
		end else if (cmd.commit && found_q && (req_type_q inside {REQ_ADD, REQ_SELECT})) begin
			age_we    = 1'b1;
			age_waddr = pick_q;
			age_wdata = '0;
		end
	end

	assign task_we = cmd.commit && found_q && req_type_q == REQ_ADD;

	always_comb begin
		resp_d.status     = STAT_OK;
		resp_d.grant_id   = 8'd0;
		resp_d.slot_index = 4'd0;
		case (req_type_q)
			REQ_ADD: begin
				if (found_q) resp_d.slot_index = pick_wide[3:0];
				else resp_d.status = STAT_FULL;
			end
			REQ_REMOVE, REQ_YIELD: begin
				if (found_q) resp_d.slot_index = pick_wide[3:0];
				else resp_d.status = STAT_NOT_FOUND;
			end
			REQ_SELECT: begin
				if (found_q) begin
					resp_d.grant_id   = best_task_q;
					resp_d.slot_index = pick_wide[3:0];
				end else begin
					resp_d.status = STAT_NONE_READY;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (task_we) task_mem[pick_q] <= task_id_q;
		if (age_we) age_mem[age_waddr] <= age_wdata;
		if (rd_active_q) begin
			task_rd_s1 <= task_mem[rd_idx_q];
			age_rd_s1  <= age_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req.req_type;
			task_id_q  <= req.task_id;
		end
		if (take) begin
			best_age_q  <= cur_age;
			best_task_q <= task_rd_s1;
		end
		if (cmd.commit) resp_q <= resp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			busy_q       <= '0;
			age_ok_q     <= '0;
			rd_active_q  <= 1'b0;
			rd_idx_q     <= '0;
			proc_vld_s1  <= 1'b0;
			proc_idx_s1  <= '0;
			found_q      <= 1'b0;
			pick_q       <= '0;
			resp_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				rd_active_q <= 1'b1;
				rd_idx_q    <= '0;
				found_q     <= 1'b0;
			end else if (rd_active_q) begin
				if (rd_idx_q == LAST_IDX) rd_active_q <= 1'b0;
				else rd_idx_q <= rd_idx_q + 1'b1;
			end
			proc_vld_s1 <= rd_active_q;
			if (rd_active_q) proc_idx_s1 <= rd_idx_q;

			if (take) begin
				found_q <= 1'b1;
				pick_q  <= proc_idx_s1;
			end
			// remove drops every match, yield frees only the first
			if (proc_vld_s1 && req_type_q == REQ_REMOVE && cur_match) begin
				valid_q[proc_idx_s1] <= 1'b0;
				busy_q[proc_idx_s1]  <= 1'b0;
			end
			if (take && req_type_q == REQ_YIELD) busy_q[proc_idx_s1] <= 1'b0;

			if (cmd.commit && found_q) begin
				if (req_type_q == REQ_ADD) begin
					valid_q[pick_q] <= 1'b1;
					busy_q[pick_q]  <= 1'b0;
				end else if (req_type_q == REQ_SELECT) begin
					busy_q[pick_q] <= 1'b1;
				end
			end
			if (age_we) age_ok_q[age_waddr] <= 1'b1;

			if (cmd.commit) resp_valid_q <= 1'b1;
			else if (resp_ready) resp_valid_q <= 1'b0;
		end
	end

	assign stat.scan_done = proc_vld_s1 && proc_idx_s1 == LAST_IDX;
	assign stat.resp_busy = resp_valid_q && !resp_ready;
	assign resp_valid     = resp_valid_q;
	assign resp           = resp_q;

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> resp_valid_q)
		else $error("commit did not raise response valid");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !rd_active_q && !proc_vld_s1)
		else $error("request loaded while a scan is running");

	a_done_after_reads: assert property (@(posedge clk) disable iff (!arst_n)
		stat.scan_done |-> !rd_active_q)
		else $error("scan finished with reads still pending");

	a_busy_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q & ~valid_q) == '0)
		else $error("busy mark on an empty slot");

endmodule

[tb/tb_oldest_first_task_slot_arbiter.sv]
`timescale 1ns / 1ps

module tb_oldest_first_task_slot_arbiter import ofts_pkg::*; ();

	localparam int NUM_SLOTS = 16;
	// keep ages narrow so saturation and ties at the ceiling come up often
	localparam int AGE_W = 4;
	localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;  // codes 5 to 7 are ignored
	localparam logic [63:0] ID_POOL = 64'h00FF_0180_55AA_7F10;
	localparam int RANDOM_PER_PHASE = 642;
	localparam int LONG_HOLD = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic resp_valid;
	logic resp_ready = 1'b0;
	resp_t resp;

	req_t pending_reqs[$];
	resp_t expected_resps[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic long_hold_req = 1'b0;
	logic hold_taken = 1'b0;
	int hold_left = 0;
	int stall_cycles = 0;
	int error_count = 0;

	// predicted slot table
	logic             slot_used  [NUM_SLOTS];
	logic             slot_held  [NUM_SLOTS];
	logic [7:0]       slot_owner [NUM_SLOTS];
	logic [AGE_W-1:0] slot_age   [NUM_SLOTS];

	oldest_first_task_slot_arbiter #(
		.NUM_SLOTS(NUM_SLOTS),
		.AGE_BITS (AGE_W)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.resp_valid(resp_valid),
		.resp_ready(resp_ready),
		.resp      (resp)
	);

	always #1 clk = ~clk;

	function automatic resp_t arbitrate(req_t r);
		resp_t rsp;
		int pick;
		rsp = '0;
		pick = -1;
		case (r.req_type)
			REQ_ADD: begin
				for (int i = NUM_SLOTS - 1; i >= 0; i--)
					if (!slot_used[i]) pick = i;
				if (pick < 0) begin
					rsp.status = STAT_FULL;
				end else begin
					slot_used[pick] = 1'b1;
					slot_held[pick] = 1'b0;
					slot_owner[pick] = r.task_id;
					slot_age[pick] = '0;
					rsp.slot_index = 4'(pick);
				end
			end
			REQ_REMOVE: begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (slot_used[i] && slot_owner[i] == r.task_id) begin
						if (pick < 0) pick = i;
						slot_used[i] = 1'b0;
						slot_held[i] = 1'b0;
					end
				end
				if (pick < 0) rsp.status = STAT_NOT_FOUND;
				else rsp.slot_index = 4'(pick);
			end
			REQ_YIELD: begin
				for (int i = NUM_SLOTS - 1; i >= 0; i--)
					if (slot_used[i] && slot_owner[i] == r.task_id) pick = i;
				if (pick < 0) begin
					rsp.status = STAT_NOT_FOUND;
				end else begin
					slot_held[pick] = 1'b0;
					rsp.slot_index = 4'(pick);
				end
			end
			REQ_SELECT: begin
				// strictly greater keeps the lowest slot on a tie
				for (int i = 0; i < NUM_SLOTS; i++)
					if (slot_used[i] && !slot_held[i] &&
					    (pick < 0 || slot_age[i] > slot_age[pick])) pick = i;
				if (pick < 0) begin
					rsp.status = STAT_NONE_READY;
				end else begin
					slot_held[pick] = 1'b1;
					slot_age[pick] = '0;
					rsp.grant_id = slot_owner[pick];
					rsp.slot_index = 4'(pick);
				end
			end
			REQ_TICK: begin
				for (int i = 0; i < NUM_SLOTS; i++)
					if (slot_age[i] != '1) slot_age[i] = slot_age[i] + 1'b1;
			end
			default: begin
			end
		endcase
		return rsp;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 20) r.req_type = REQ_ADD;
		else if (roll < 33) r.req_type = REQ_REMOVE;
		else if (roll < 48) r.req_type = REQ_YIELD;
		else if (roll < 73) r.req_type = REQ_SELECT;
		else if (roll < 95) r.req_type = REQ_TICK;
		else r.req_type = REQ_SPARE_FIRST + 3'($urandom_range(0, 2));
		// mostly reuse a few ids so remove and yield find their targets
		if ($urandom_range(0, 3) == 0) r.task_id = 8'($urandom);
		else r.task_id = ID_POOL[8 * $urandom_range(0, 7) +: 8];
		return r;
	endfunction

	task automatic push_req(logic [2:0] kind, logic [7:0] id);
		req_t r;
		r.req_type = kind;
		r.task_id = id;
		pending_reqs.push_back(r);
	endtask

	task automatic queue_random(int count);
		req_t r;
		int n;
		n = 0;
		while (n < count) begin
			r = random_request();
			pending_reqs.push_back(r);
			n++;
		end
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || req_valid || expected_resps.size() > 0)
			@(negedge clk);
	endtask

	task automatic check_response(resp_t got);
		resp_t want;
		if (expected_resps.size() == 0) begin
			$error("response with nothing outstanding: status %0d grant_id %0d slot_index %0d",
			       got.status, got.grant_id, got.slot_index);
			error_count++;
		end else begin
			want = expected_resps.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				error_count++;
			end
			if (got.grant_id !== want.grant_id) begin
				$error("grant_id: expected %0d, actual %0d", want.grant_id, got.grant_id);
				error_count++;
			end
			if (got.slot_index !== want.slot_index) begin
				$error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
				error_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && req_ready) expected_resps.push_back(arbitrate(req));
			if (!req_valid || req_ready) begin
				if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req <= pending_reqs.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_ready <= 1'b0;
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else begin
			if (resp_valid && resp_ready) check_response(resp);
			if (long_hold_req && !hold_taken) begin
				hold_taken <= 1'b1;
				hold_left <= LONG_HOLD;
				resp_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				resp_ready <= 1'b0;
			end else begin
				resp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (resp_valid && resp_ready)) stall_cycles <= 0;
			else stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_held[i] = 1'b0;
			slot_owner[i] = '0;
			slot_age[i] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 23;
		recv_idle_pct = 54;
		// empty table: nothing to grant, unknown ids, ignored code
		push_req(REQ_SELECT, 8'h00);
		push_req(REQ_REMOVE, 8'h00);
		push_req(REQ_YIELD, 8'hFF);
		push_req(REQ_SPARE_FIRST + 3'd2, 8'hFF);
		// fill every slot, with a duplicate id, then overflow
		push_req(REQ_ADD, 8'h00);
		push_req(REQ_ADD, 8'hFF);
		push_req(REQ_ADD, 8'hFF);
		for (int i = 3; i < NUM_SLOTS; i++) push_req(REQ_ADD, 8'(i * 19));
		push_req(REQ_ADD, 8'h5A);
		// equal ages: lowest slot wins, then yield a slot that is not busy
		push_req(REQ_TICK, 8'h00);
		push_req(REQ_SELECT, 8'hFF);
		push_req(REQ_YIELD, 8'hFF);
		push_req(REQ_REMOVE, 8'hFF);
		push_req(REQ_SPARE_FIRST, 8'h00);
		queue_random(RANDOM_PER_PHASE);
		wait_drained();

		send_idle_pct = 54;
		recv_idle_pct = 23;
		queue_random(RANDOM_PER_PHASE);
		wait_drained();

		// no idling, but stall responses long enough to back up requests
		send_idle_pct = 0;
		recv_idle_pct = 0;
		long_hold_req = 1'b1;
		queue_random(RANDOM_PER_PHASE);
		wait_drained();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[files.f]
sv/ofts_pkg.sv
sv/ofts_ctrl.sv
sv/ofts_datapath.sv
sv/oldest_first_task_slot_arbiter.sv
tb/tb_oldest_first_task_slot_arbiter.sv
